// File: hdl/bbtwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbtwc_pkg;

    // Field widths fixed by the interface
    localparam int HEADING_W = 24;
    localparam int TARGET_W  = 16;
    localparam int POWER_W   = 7;
    localparam int MARGIN_W  = 7;
    localparam int SETTLE_W  = 8;
    localparam int DRIVE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEGREES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_DRIVE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECT_DRIVE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 3'd4;

    // Register reset values
    localparam logic [TARGET_W-1:0] RST_TARGET_DEGREES  = 16'd0;
    localparam logic [POWER_W-1:0]  RST_TURN_DRIVE      = 7'd0;
    localparam logic [MARGIN_W-1:0] RST_APPROACH_MARGIN = 7'd5;
    localparam logic [POWER_W-1:0]  RST_CORRECT_DRIVE   = 7'd30;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_TICKS    = 8'd10;

    // Input word modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TURN    = 4'b0010,
        PH_SETTLE  = 4'b0100,
        PH_CORRECT = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

// File: hdl/bang_bang_turn_with_correction.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Word
// ------    -------------------------  ------------------------------------------
// input     i_in_valid / o_in_ready    i_mode, i_heading
// result    o_out_valid / i_out_ready  o_left_drive, o_right_drive, o_busy_res, o_reset_encoders
// config    i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One word in, one word out. A word lands in the input register; the step runs when the
// output register is free or draining, and writes the output register. One word per
// cycle sustained while i_out_ready stays high.
// Reset (i_rst_n low, synchronous) empties both registers, idles the sequencer and
// loads the register defaults.
// A stalled output holds the input register, which drops o_in_ready; nothing is lost.

module bang_bang_turn_with_correction
    import bbtwc_pkg::*;
#(
    parameter int HEADING_FRACTION_BITS = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0]        i_cfg_data,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_mode,
    input  wire logic signed [HEADING_W-1:0] i_heading,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [DRIVE_W-1:0]        o_left_drive,
    output logic signed [DRIVE_W-1:0]        o_right_drive,
    output logic                             o_busy_res,
    output logic                             o_reset_encoders
);

    // Compare width: scaled target +/- scaled margin, or the heading, plus a sign bit
    localparam int SUM_W = TARGET_W + HEADING_FRACTION_BITS + 2;
    localparam int CMP_W = ((SUM_W > HEADING_W) ? SUM_W : HEADING_W) + 1;

    // ---------------- configuration registers ----------------
    logic signed [TARGET_W-1:0] r_target;
    logic [POWER_W-1:0]         r_turn_drive;
    logic [MARGIN_W-1:0]        r_margin;
    logic [POWER_W-1:0]         r_correct_drive;
    logic [SETTLE_W-1:0]        r_settle_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target        <= RST_TARGET_DEGREES;
            r_turn_drive    <= RST_TURN_DRIVE;
            r_margin        <= RST_APPROACH_MARGIN;
            r_correct_drive <= RST_CORRECT_DRIVE;
            r_settle_ticks  <= RST_SETTLE_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_DEGREES:  r_target        <= i_cfg_data[TARGET_W-1:0];
                CFG_TURN_DRIVE:      r_turn_drive    <= i_cfg_data[POWER_W-1:0];
                CFG_APPROACH_MARGIN: r_margin        <= i_cfg_data[MARGIN_W-1:0];
                CFG_CORRECT_DRIVE:   r_correct_drive <= i_cfg_data[POWER_W-1:0];
                CFG_SETTLE_TICKS:    r_settle_ticks  <= i_cfg_data[SETTLE_W-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                        r_in_vld;
    logic                        r_mode;
    logic signed [HEADING_W-1:0] r_heading;
    logic                        r_out_vld;
    logic                        step;

    // The step fires when a word is held and the output register is free or draining
    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode    <= i_mode;
            r_heading <= i_heading;
        end
    end

    // ---------------- controller step ----------------
    t_phase                r_phase,    n_phase;
    logic                  r_turn_sign, n_turn_sign;
    logic                  r_corr_sign, n_corr_sign;
    logic [SETTLE_W-1:0]   r_settle_cnt, n_settle_cnt;

    logic signed [CMP_W-1:0]   head_x, tgt_x, mar_x, tgt_lo, tgt_hi;
    logic signed [DRIVE_W-1:0] turn_pos, turn_neg, corr_pos, corr_neg;
    t_phase                    ph_eff;
    logic                      sign_eff;
    logic                      going;

    logic signed [DRIVE_W-1:0] n_left, n_right;
    logic                      n_busy, n_pulse;

    assign head_x = CMP_W'(r_heading);
    assign tgt_x  = CMP_W'(r_target) <<< HEADING_FRACTION_BITS;
    assign mar_x  = $signed(CMP_W'(r_margin) << HEADING_FRACTION_BITS);
    assign tgt_lo = tgt_x - mar_x;
    assign tgt_hi = tgt_x + mar_x;

    assign turn_pos = $signed({1'b0, r_turn_drive});
    assign turn_neg = -turn_pos;
    assign corr_pos = $signed({1'b0, r_correct_drive});
    assign corr_neg = -corr_pos;

    // A start word forces the turn phase and picks the direction from its own heading
    assign ph_eff   = (r_mode == MODE_START) ? PH_TURN : r_phase;
    assign sign_eff = (r_mode == MODE_START) ? (tgt_x < head_x) : r_turn_sign;
    assign going    = sign_eff ? (head_x > tgt_hi) : (head_x < tgt_lo);

    always_comb begin
        n_phase      = ph_eff;
        n_turn_sign  = sign_eff;
        n_corr_sign  = r_corr_sign;
        n_settle_cnt = r_settle_cnt;
        n_left       = '0;
        n_right      = '0;
        n_busy       = 1'b1;
        n_pulse      = 1'b0;
        case (ph_eff)
            PH_TURN: begin
                if (going) begin
                    n_left  = sign_eff ? turn_neg : turn_pos;
                    n_right = sign_eff ? turn_pos : turn_neg;
                end else begin
                    n_phase      = PH_SETTLE;
                    n_settle_cnt = r_settle_ticks;
                end
            end
            PH_SETTLE: begin
                if (r_settle_cnt != '0) begin
                    n_settle_cnt = r_settle_cnt - 1'b1;
                end else if (head_x > tgt_x) begin
                    n_corr_sign = 1'b1;
                    n_phase     = PH_CORRECT;
                    n_left      = corr_neg;
                    n_right     = corr_pos;
                end else if (head_x < tgt_x) begin
                    n_corr_sign = 1'b0;
                    n_phase     = PH_CORRECT;
                    n_left      = corr_pos;
                    n_right     = corr_neg;
                end else begin
                    // exactly on target after settling
                    n_phase = PH_IDLE;
                    n_busy  = 1'b0;
                    n_pulse = 1'b1;
                end
            end
            PH_CORRECT: begin
                if (r_corr_sign && (head_x > tgt_x)) begin
                    n_left  = corr_neg;
                    n_right = corr_pos;
                end else if (!r_corr_sign && (head_x < tgt_x)) begin
                    n_left  = corr_pos;
                    n_right = corr_neg;
                end else begin
                    n_phase = PH_IDLE;
                    n_busy  = 1'b0;
                    n_pulse = 1'b1;
                end
            end
            default: begin
                // idle tick, or a phase code that means nothing
                n_phase = PH_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_turn_sign  <= 1'b0;
            r_corr_sign  <= 1'b0;
            r_settle_cnt <= '0;
        end else if (step) begin
            r_phase      <= n_phase;
            r_turn_sign  <= n_turn_sign;
            r_corr_sign  <= n_corr_sign;
            r_settle_cnt <= n_settle_cnt;
        end
    end

    // ---------------- output register ----------------
    logic signed [DRIVE_W-1:0] r_left, r_right;
    logic                      r_busy, r_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_busy  <= n_busy;
            r_pulse <= n_pulse;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_left_drive     = r_left;
    assign o_right_drive    = r_right;
    assign o_busy_res       = r_busy;
    assign o_reset_encoders = r_pulse;

    // ---------------- assertions ----------------
    a_pulse_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reset_encoders |-> !o_busy_res && o_left_drive == '0
            && o_right_drive == '0)
        else $error("completion word not idle with zero drive");

    a_opposite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left_drive == -o_right_drive)
        else $error("wheels not driven opposite");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_mode == MODE_START |=> r_phase == PH_TURN || r_phase == PH_SETTLE)
        else $error("start word did not enter turn or settle");

    a_settle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_mode == MODE_TICK && r_phase == PH_SETTLE && r_settle_cnt != '0
            |=> r_phase == PH_SETTLE
                && r_settle_cnt == SETTLE_W'($past(r_settle_cnt) - 1'b1))
        else $error("settle count did not step down");

    a_no_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_phase) && $stable(r_settle_cnt))
        else $error("state moved without a step");

endmodule

`default_nettype wire
